>>> sv/wspd_pkg.sv
// ----------------------------------------------------------------------------
// wspd_pkg: shared types and constants for the wheel speed controller
// Field widths, limits, datapath commands and register indexes.
// ----------------------------------------------------------------------------
package wspd_pkg;

    localparam int MEAS_W     = 14;
    localparam int TGT_W      = 13;
    localparam int EFF_W      = 12;
    localparam int ISUM_W     = 10;
    localparam int ERR_W      = 15;
    localparam int GAIN_W     = 8;
    localparam int PROD_W     = ERR_W + GAIN_W + 1;
    localparam int ACC_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [EFF_W-1:0] STOP_BAND_LOW  = 12'd2100;
    localparam logic [EFF_W-1:0] STOP_BAND_HIGH = 12'd2500;
    localparam logic [EFF_W-1:0] EFFORT_MIN     = 12'd1;
    localparam logic [EFF_W-1:0] EFFORT_MAX     = 12'd3999;
    localparam logic [12:0]      SPEED_MAX      = 13'd8191;
    localparam int               INTEGRAL_LIMIT = 400;
    localparam int               EFF_FRAC       = 6;

    // x * 9 / 10 as (x * 9) * 52429 >> 19, exact for x * 9 below 43690
    localparam logic [15:0] DECAY_RECIP = 16'd52429;
    localparam int          DECAY_SHIFT = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIR,
        OP_ERR,
        OP_INT,
        OP_MAC_P,
        OP_MAC_I,
        OP_MAC_D,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic enc_valid;
    } t_dp_sts;

endpackage

>>> sv/wspd_in_if.sv
// ----------------------------------------------------------------------------
// wspd_in_if: encoder tick channel
// Valid/ready channel carrying one encoder item per tick.
// ----------------------------------------------------------------------------
interface wspd_in_if import wspd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAS_W-1:0] measured_speed;
    logic signed [TGT_W-1:0]  target_speed;
    logic                     encoder_valid;

    modport source (output valid, output measured_speed, output target_speed,
                    output encoder_valid, input ready);
    modport sink   (input valid, input measured_speed, input target_speed,
                    input encoder_valid, output ready);
endinterface

>>> sv/wspd_out_if.sv
// ----------------------------------------------------------------------------
// wspd_out_if: drive result channel
// Valid/ready channel carrying the drive effort and signed speed.
// ----------------------------------------------------------------------------
interface wspd_out_if import wspd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [EFF_W-1:0]  drive_effort;
    logic signed [MEAS_W-1:0] signed_speed;

    modport source (output valid, output drive_effort, output signed_speed,
                    input ready);
    modport sink   (input valid, input drive_effort, input signed_speed,
                    output ready);
endinterface

>>> sv/wspd_ctrl.sv
// ----------------------------------------------------------------------------
// wspd_ctrl: control sequencer
// Steps the datapath through direction, error, integral, three gain
// products and commit; owns the input ready and result valid.
// ----------------------------------------------------------------------------
module wspd_ctrl import wspd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_ERR,
        S_INT,
        S_MP,
        S_MI,
        S_MD,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DIR;
                end
            end
            S_DIR: begin
                if (i_sts.enc_valid) begin
                    o_cmd.op = OP_DIR;
                    n_state  = S_ERR;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_INT;
            end
            S_INT: begin
                o_cmd.op = OP_INT;
                n_state  = S_MP;
            end
            S_MP: begin
                o_cmd.op = OP_MAC_P;
                n_state  = S_MI;
            end
            S_MI: begin
                o_cmd.op = OP_MAC_I;
                n_state  = S_MD;
            end
            S_MD: begin
                o_cmd.op = OP_MAC_D;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_slot_free) begin
                    o_cmd.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/wspd_datapath.sv
// ----------------------------------------------------------------------------
// wspd_datapath: direction inference and PID arithmetic
// Holds controller state and gains; one shared multiplier feeds the
// effort accumulator over three steps.
// ----------------------------------------------------------------------------
module wspd_datapath import wspd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic signed [MEAS_W-1:0] i_measured_speed,
    input  logic signed [TGT_W-1:0]  i_target_speed,
    input  logic                     i_encoder_valid,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic [EFF_W-1:0]         o_drive_effort,
    output logic signed [MEAS_W-1:0] o_signed_speed
);

    localparam logic [1:0] DIR_NEG  = 2'b11;
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;

    // gains and threshold
    logic [CFG_DATA_W-1:0] r_thr;
    logic [GAIN_W-1:0]     r_kp, r_ki, r_kd;

    // controller state
    logic [1:0]               r_dir, n_dir;
    logic                     r_rev, n_rev;
    logic signed [MEAS_W-1:0] r_prev_spd;
    logic [EFF_W-1:0]         r_prev_eff;
    logic signed [ISUM_W-1:0] r_isum, n_isum;
    logic [EFF_W-1:0]         r_eff, n_eff;
    logic signed [MEAS_W-1:0] r_held;

    // per-item work registers
    logic signed [MEAS_W-1:0] r_meas;
    logic signed [TGT_W-1:0]  r_tgt;
    logic                     r_encv;
    logic signed [MEAS_W-1:0] r_sp, n_sp;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [ERR_W-1:0]  r_dspd, n_dspd;
    logic                     r_accum, n_accum;
    logic [EFF_W-1:0]         r_mag9, n_mag9;
    logic signed [ACC_W-1:0]  r_acc;

    // direction
    logic signed [EFF_W:0]  w_de;
    logic [EFF_W:0]         w_de_mag;
    logic signed [ERR_W-1:0] w_num;
    logic [ERR_W-1:0]       w_num_mag;
    logic                   w_q_nz;
    logic                   w_in_band;
    logic signed [MEAS_W-1:0] w_meas_abs;
    logic [12:0]            w_meas_mag;
    logic                   w_neg_out;

    // error and integral
    logic [ERR_W-1:0]       w_abserr;
    logic [ISUM_W-2:0]      w_isum_mag;
    logic signed [15:0]     w_isum_sum;
    logic [27:0]            w_dec_prod;
    logic [8:0]             w_dec_q;
    logic [ISUM_W-1:0]      w_dec_val;

    // shared multiplier
    logic signed [ERR_W-1:0]  w_mul_a;
    logic [GAIN_W-1:0]        w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_addend;
    logic signed [ACC_W-1:0]  w_eff_q;

    assign o_sts.enc_valid = r_encv;
    assign o_drive_effort  = r_eff;
    assign o_signed_speed  = r_held;

    // direction inference
    assign w_in_band = (r_eff > STOP_BAND_LOW) && (r_eff < STOP_BAND_HIGH);
    assign w_de      = $signed({1'b0, r_eff}) - $signed({1'b0, r_prev_eff});
    assign w_de_mag  = w_de[EFF_W] ? 13'(-w_de) : 13'(w_de);
    assign w_num     = $signed({r_meas[MEAS_W-1], r_meas})
                     - $signed({r_prev_spd[MEAS_W-1], r_prev_spd});
    assign w_num_mag = w_num[ERR_W-1] ? 15'(-w_num) : 15'(w_num);
    assign w_q_nz    = w_num_mag >= {2'b00, w_de_mag};

    always_comb begin
        n_dir = r_dir;
        if (w_in_band) begin
            if (w_de != '0) begin
                if (!w_q_nz) begin
                    n_dir = DIR_ZERO;
                end else if (w_num[ERR_W-1] ^ w_de[EFF_W]) begin
                    n_dir = DIR_NEG;
                end else begin
                    n_dir = DIR_POS;
                end
            end
        end else if (r_eff <= STOP_BAND_LOW) begin
            n_dir = DIR_NEG;
        end else begin
            n_dir = DIR_POS;
        end
    end

    assign w_meas_abs = r_meas[MEAS_W-1] ? -r_meas : r_meas;
    assign w_meas_mag = (r_meas == $signed(14'h2000)) ? SPEED_MAX : w_meas_abs[12:0];
    assign w_neg_out  = (n_dir == DIR_NEG) || ((n_dir == DIR_ZERO) && r_rev);
    assign n_rev      = w_neg_out;
    assign n_sp       = w_neg_out ? -$signed({1'b0, w_meas_mag})
                                  : $signed({1'b0, w_meas_mag});

    // error, speed drop, decay prep
    assign n_err    = $signed({{2{r_tgt[TGT_W-1]}}, r_tgt})
                    - $signed({r_sp[MEAS_W-1], r_sp});
    assign w_abserr = n_err[ERR_W-1] ? 15'(-n_err) : 15'(n_err);
    assign n_accum  = w_abserr > {3'b000, r_thr};
    assign n_dspd   = $signed({r_prev_spd[MEAS_W-1], r_prev_spd})
                    - $signed({r_sp[MEAS_W-1], r_sp});
    assign w_isum_mag = r_isum[ISUM_W-1] ? 9'(-r_isum) : 9'(r_isum);
    assign n_mag9     = {w_isum_mag, 3'b000} + {3'b000, w_isum_mag};

    // integral update
    assign w_isum_sum = $signed({{6{r_isum[ISUM_W-1]}}, r_isum})
                      + $signed({r_err[ERR_W-1], r_err});
    assign w_dec_prod = {16'd0, r_mag9} * {12'd0, DECAY_RECIP};
    assign w_dec_q    = w_dec_prod[DECAY_SHIFT +: 9];
    assign w_dec_val  = r_isum[ISUM_W-1] ? 10'(-{1'b0, w_dec_q}) : {1'b0, w_dec_q};

    always_comb begin
        if (r_accum) begin
            if (w_isum_sum > 16'sd400) begin
                n_isum = 10'(INTEGRAL_LIMIT);
            end else if (w_isum_sum < -16'sd400) begin
                n_isum = 10'(-INTEGRAL_LIMIT);
            end else begin
                n_isum = w_isum_sum[ISUM_W-1:0];
            end
        end else begin
            n_isum = w_dec_val;
        end
    end

    // gain products
    always_comb begin
        w_mul_a = r_err;
        w_mul_b = r_kp;
        case (i_cmd.op)
            OP_MAC_P: begin
                w_mul_a = r_err;
                w_mul_b = r_kp;
            end
            OP_MAC_I: begin
                w_mul_a = $signed({{(ERR_W-ISUM_W){r_isum[ISUM_W-1]}}, r_isum});
                w_mul_b = r_ki;
            end
            OP_MAC_D: begin
                w_mul_a = r_dspd;
                w_mul_b = r_kd;
            end
            default: begin
                w_mul_a = r_err;
                w_mul_b = r_kp;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            OP_MAC_P: begin
                w_addend = w_prod_ext <<< 2;
            end
            OP_MAC_I: begin
                w_addend = w_prod_ext;
            end
            OP_MAC_D: begin
                w_addend = w_prod_ext <<< 1;
            end
            default: begin
                w_addend = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * $signed({1'b0, w_mul_b});
    assign w_prod_ext = $signed({{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod});

    // effort = floor(acc / 64) clamped to 1..3999
    assign w_eff_q = r_acc >>> EFF_FRAC;
    always_comb begin
        if (r_acc < $signed(ACC_W'(64))) begin
            n_eff = EFFORT_MIN;
        end else if (w_eff_q > $signed({{(ACC_W-EFF_W){1'b0}}, EFFORT_MAX})) begin
            n_eff = EFFORT_MAX;
        end else begin
            n_eff = w_eff_q[EFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= '0;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_dir      <= DIR_ZERO;
            r_rev      <= 1'b0;
            r_prev_spd <= '0;
            r_prev_eff <= '0;
            r_isum     <= '0;
            r_eff      <= '0;
            r_held     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr <= i_cfg_data;
                    CFG_GAIN_P:    r_kp  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    r_ki  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    r_kd  <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                OP_DIR: begin
                    r_dir <= n_dir;
                    r_rev <= n_rev;
                end
                OP_INT: begin
                    r_isum <= n_isum;
                end
                OP_COMMIT: begin
                    r_prev_eff <= r_eff;
                    if (r_encv) begin
                        r_eff      <= n_eff;
                        r_held     <= r_sp;
                        r_prev_spd <= r_sp;
                    end else begin
                        r_prev_spd <= r_meas;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_meas <= i_measured_speed;
                r_tgt  <= i_target_speed;
                r_encv <= i_encoder_valid;
            end
            OP_DIR: begin
                r_sp <= n_sp;
            end
            OP_ERR: begin
                r_err   <= n_err;
                r_dspd  <= n_dspd;
                r_accum <= n_accum;
                r_mag9  <= n_mag9;
            end
            OP_INT: begin
                r_acc <= $signed({{(ACC_W-EFF_W-EFF_FRAC){1'b0}}, r_eff, 6'd0});
            end
            OP_MAC_P, OP_MAC_I, OP_MAC_D: begin
                r_acc <= r_acc + w_addend;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/wheel_speed_pid_with_direction.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_with_direction: wheel speed PID with direction inference
// Signs the encoder speed from the drive effort history and updates the
// drive effort with a clamped PID step on each valid encoder tick.
// ----------------------------------------------------------------------------
// One item is taken at a time. A tick with encoder_valid set steps through
// load, direction, error, integral, then the proportional, integral and
// derivative products through one shared multiplier, and a commit, before
// the next acceptance. A tick without encoder_valid skips from load to commit.
// The result is held in the output stage until taken; a commit waits for it
// to clear. Register writes take effect at once and belong between items.
module wheel_speed_pid_with_direction import wspd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wspd_in_if.sink               i_in,
    wspd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    wspd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    wspd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_measured_speed (i_in.measured_speed),
        .i_target_speed   (i_in.target_speed),
        .i_encoder_valid  (i_in.encoder_valid),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_drive_effort   (o_out.drive_effort),
        .o_signed_speed   (o_out.signed_speed)
    );

endmodule

>>> sv/wspd_checker.sv
// ----------------------------------------------------------------------------
// wspd_checker: port-level checks for the wheel speed controller
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
module wspd_checker import wspd_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [EFF_W-1:0]         i_drive_effort,
    input logic signed [MEAS_W-1:0] i_signed_speed
);

    // one item in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after accept");

    // a new result only appears while an item is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");

    a_effort_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drive_effort <= EFFORT_MAX))
        else $error("drive effort out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_drive_effort) && $stable(i_signed_speed)))
        else $error("stalled result changed");

endmodule

bind wheel_speed_pid_with_direction wspd_checker u_wspd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_drive_effort (o_out.drive_effort),
    .i_signed_speed (o_out.signed_speed)
);

>>> tb/sv/wspd_drive_check.sv
// ----------------------------------------------------------------------------
// wspd_drive_check: result checker for the wheel speed controller
// Watches the encoder, result and register ports, predicts the drive effort
// and signed speed for every accepted item, and compares them in order.
// ----------------------------------------------------------------------------
module wspd_drive_check import wspd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wspd_in_if                    in_ch,
    wspd_out_if                   out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    typedef struct packed {
        logic        [EFF_W-1:0]  effort;
        logic signed [MEAS_W-1:0] speed;
    } t_drive_result;

    // register copies
    logic [EFF_W-1:0]  thr_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;

    // controller state copy
    int     dir_est;
    bit     rev_latch;
    longint last_speed;
    longint last_effort;
    longint integ;
    longint effort;
    longint held_speed;

    t_drive_result drive_expect[$];
    t_drive_result want;
    int            fails;
    int            results_seen;

    function automatic longint speed_mag(input longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a > longint'(SPEED_MAX)) ? longint'(SPEED_MAX) : a;
    endfunction

    function automatic t_drive_result step_controller(
        input logic signed [MEAS_W-1:0] meas_raw,
        input logic signed [TGT_W-1:0]  tgt_raw,
        input logic                     enc_ok
    );
        longint        meas;
        longint        tgt;
        longint        eff_in;
        longint        de;
        longint        q;
        longint        sp;
        longint        err;
        longint        abserr;
        longint        total;
        longint        band_lo;
        longint        band_hi;
        t_drive_result r;
        meas    = meas_raw;
        tgt     = tgt_raw;
        eff_in  = effort;
        band_lo = longint'(STOP_BAND_LOW);
        band_hi = longint'(STOP_BAND_HIGH);
        if (enc_ok) begin
            if (effort > band_lo && effort < band_hi) begin
                de = effort - last_effort;
                if (de != 0) begin
                    q = (meas - last_speed) / de;
                    dir_est = (q < 0) ? -1 : ((q > 0) ? 1 : 0);
                end
            end else if (effort <= band_lo) begin
                dir_est = -1;
            end else begin
                dir_est = 1;
            end

            if (dir_est < 0) begin
                sp = -speed_mag(meas);
                rev_latch = 1'b1;
            end else if (dir_est == 0 && rev_latch) begin
                sp = -speed_mag(meas);
            end else begin
                sp = speed_mag(meas);
                rev_latch = 1'b0;
            end

            err = tgt - sp;
            abserr = (err < 0) ? -err : err;
            if (abserr > longint'(thr_reg))
                integ = integ + err;
            else
                integ = (integ * 9) / 10;
            if (integ > INTEGRAL_LIMIT)
                integ = INTEGRAL_LIMIT;
            else if (integ < -INTEGRAL_LIMIT)
                integ = -INTEGRAL_LIMIT;

            total = effort * 64
                  + err * longint'(kp_reg) * 4
                  + integ * longint'(ki_reg)
                  + (last_speed - sp) * longint'(kd_reg) * 2;
            if (total < 64 * longint'(EFFORT_MIN))
                effort = longint'(EFFORT_MIN);
            else if (total / 64 > longint'(EFFORT_MAX))
                effort = longint'(EFFORT_MAX);
            else
                effort = total / 64;

            held_speed = sp;
            last_speed = sp;
        end else begin
            last_speed = meas;
        end
        last_effort = eff_in;
        r.effort = effort[EFF_W-1:0];
        r.speed  = held_speed[MEAS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch on result %0d: %s", results_seen, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_reg     <= '0;
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            dir_est     = 0;
            rev_latch   = 1'b0;
            last_speed  = 0;
            last_effort = 0;
            integ       = 0;
            effort      = 0;
            held_speed  = 0;
            drive_expect.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (drive_expect.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else begin
                    want = drive_expect.pop_front();
                    if (out_ch.drive_effort !== want.effort)
                        report_mismatch($sformatf("drive_effort %0d, expected %0d",
                                                  out_ch.drive_effort, want.effort));
                    if (out_ch.signed_speed !== want.speed)
                        report_mismatch($sformatf("signed_speed %0d, expected %0d",
                                                  out_ch.signed_speed, want.speed));
                end
                results_seen++;
            end
            if (in_ch.valid && in_ch.ready)
                drive_expect.push_back(step_controller(in_ch.measured_speed,
                                                       in_ch.target_speed,
                                                       in_ch.encoder_valid));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thr_reg <= i_cfg_data;
                    CFG_GAIN_P:    kp_reg  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    ki_reg  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    kd_reg  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= drive_expect.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for wheel_speed_pid_with_direction
// Drives encoder items and register settings with random idling on both
// channels, a long result stall, and a final phase at full rate.
// ----------------------------------------------------------------------------
module tb import wspd_pkg::*; ();

    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES  = 10;
    localparam int HOLD_CYCLES = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    bit                    calm;
    bit                    hold_req;

    wspd_in_if  in_ch();
    wspd_out_if out_ch();

    wheel_speed_pid_with_direction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wspd_drive_check drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic send_item(input int m, input int t, input logic ev);
        in_ch.valid          <= 1'b1;
        in_ch.measured_speed <= m[MEAS_W-1:0];
        in_ch.target_speed   <= t[TGT_W-1:0];
        in_ch.encoder_valid  <= ev;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] thr,
                                  input logic [CFG_DATA_W-1:0] kp,
                                  input logic [CFG_DATA_W-1:0] ki,
                                  input logic [CFG_DATA_W-1:0] kd);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge i_clk);
        cfg_index <= CFG_GAIN_P;
        cfg_data  <= kp;
        @(posedge i_clk);
        cfg_index <= CFG_GAIN_I;
        cfg_data  <= ki;
        @(posedge i_clk);
        cfg_index <= CFG_GAIN_D;
        cfg_data  <= kd;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small gains so the effort wanders through the stop band;
    // upper data bits above an 8-bit register are sometimes set
    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        logic [CFG_DATA_W-1:0] g;
        logic [31:0]           bits;
        bits = $urandom;
        g = '0;
        if ($urandom_range(0, 3) == 0)
            g[7:0] = bits[7:0];
        else
            g[7:0] = 8'($urandom_range(0, 32));
        if ($urandom_range(0, 3) == 0)
            g[11:8] = bits[11:8];
        return g;
    endfunction

    task automatic send_random;
        int          m;
        int          t;
        logic        ev;
        logic [31:0] bits;
        bits = $urandom;
        if ($urandom_range(0, 9) < 7) begin
            m = int'($urandom_range(0, 1600)) - 800;
            t = int'($urandom_range(0, 1600)) - 800;
        end else begin
            m = int'(bits[13:0]);
            t = int'(bits[28:16]);
        end
        ev = ($urandom_range(0, 99) < 85);
        send_item(m, t, ev);
    endtask

    // result side: random bursts, one long hold-off, none at the end
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(12 * 500000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.measured_speed <= '0;
        in_ch.target_speed   <= '0;
        in_ch.encoder_valid  <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_THRESHOLD;
        cfg_data             <= '0;
        calm                 = 1'b0;
        hold_req             = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // steer the effort into the stop band and walk the direction cases
        write_settings(12'd4095, 12'd16, 12'd0, 12'd0);
        send_item(0, 2300, 1'b1);
        send_item(2300, 2300, 1'b1);
        send_item(2300, 2300, 1'b1);
        send_item(2300, 2200, 1'b1);
        send_item(2500, -2500, 1'b1);
        send_item(2500, -2400, 1'b1);
        send_item(-2450, -2450, 1'b1);
        send_item(-2450, -2450, 1'b1);
        send_item(1234, 0, 1'b0);
        send_item(-8192, 0, 1'b1);
        send_item(-8192, 4095, 1'b0);
        send_item(8191, -4096, 1'b1);
        send_item(0, 4095, 1'b1);
        drain();

        // full gains, field extremes, integral accumulating on any nonzero error
        write_settings(12'd0, 12'd255, 12'd255, 12'd255);
        send_item(8191, 4095, 1'b1);
        send_item(-8192, -4096, 1'b1);
        send_item(0, 0, 1'b1);
        send_item(-8192, 4095, 1'b0);
        send_item(8191, -4096, 1'b1);
        send_item(-1, 1, 1'b1);
        drain();

        // integral decay, upper data bits ignored by 8-bit registers
        write_settings(12'd4095, 12'hF20, 12'h140, 12'hA00);
        send_item(100, 200, 1'b1);
        send_item(100, 200, 1'b1);
        send_item(100, 200, 1'b1);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
                1: write_settings(12'd0, 12'd0, 12'd0, 12'd0);
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        write_settings(12'($urandom_range(0, 4095)), rand_gain(),
                                       rand_gain(), rand_gain());
                    else
                        write_settings(12'($urandom_range(0, 400)), rand_gain(),
                                       rand_gain(), rand_gain());
                end
            endcase
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == NUM_PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
